// ===== hw/rtl/mhpq_pkg.sv =====
// Package for the min-heap priority queue: sizes, entry and transfer types,
// operation and status codes, sequencer states. No dependencies.
`default_nettype none
package mhpq_pkg;
    localparam int unsigned DEPTH = 1024;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = 11;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_INSERT = 2'd0;
    localparam t_mode MODE_POP    = 2'd1;
    localparam t_mode MODE_ERASE  = 2'd2;
    localparam t_mode MODE_NOP    = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [31:0] key;
        logic [30:0] id;
        logic [47:0] tstamp;
    } t_entry;

    localparam int unsigned EW = $bits(t_entry);

    typedef struct packed {
        t_mode       mode;
        logic [31:0] entry_key;
        logic [30:0] entry_id;
        logic [47:0] entry_time;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [10:0] entry_count;
        logic        removed_valid;
        logic [31:0] removed_key;
        logic [30:0] removed_id;
        logic [47:0] removed_time;
        logic        head_valid;
        logic [31:0] head_key;
        logic [30:0] head_id;
        logic [47:0] head_time;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE,
        S_POP_RD,   // read root
        S_POP_WT,
        S_DN_RD,    // read left, then right child
        S_DN_RL,
        S_DN_RR,
        S_DN_CMP,
        S_UP_RD,    // read parent
        S_UP_WT,
        S_UP_CMP,
        S_ER_RD,    // erase scan read
        S_ER_WT,
        S_ER_CHK,
        S_HEAD_RD,
        S_HEAD_WT,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

// ===== hw/rtl/mhpq_ram.sv =====
// Generic single-port RAM, registered read.
// No dependencies.
`default_nettype none
module mhpq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/min_heap_priority_queue_core.sv =====
// Top level of the min-heap priority queue: sequencer, one entry RAM.
// Depends on mhpq_pkg and mhpq_ram.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------
//  in      | sink      | i_in_valid/o_in_ready   | i_in   (t_in)
//  out     | source    | o_out_valid/i_out_ready | o_out (t_out)
//
// One item at a time. Every RAM access goes through the single port, with
// a registered read. Insert: a parent read per level climbed. Pop: per
// level descended, two child reads and a compare. Erase: per entry a scan
// read, plus the climb for each surviving entry.
// Reset clears only the count and control; RAM contents are undefined
// until written. The result waits in o_out while the downstream stalls;
// the next input transfer is still taken, and that item holds in its last
// state until o_out is free.
`default_nettype none
module min_heap_priority_queue_core
    import mhpq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out
);
    t_state r_state, n_state;
    t_in    r_in, n_in;
    logic [CW-1:0] r_cnt, n_cnt;     // occupancy
    logic [CW-1:0] r_scan, n_scan;   // erase read index
    logic [CW-1:0] r_wr, n_wr;       // erase write index
    logic [AW-1:0] r_pos, n_pos;     // sift position
    t_entry r_cur, n_cur;            // entry being sifted
    t_entry r_lft, n_lft;
    t_out   r_res, n_res;            // result under construction
    t_out   r_out, n_out;
    logic   r_ovld, n_ovld;

    logic          we;
    logic [AW-1:0] addr;
    t_entry        wdata, rdata;

    mhpq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    logic [CW:0]   lidx, ridx;
    logic [AW-1:0] par;
    always_comb begin
        lidx = {1'b0, r_pos, 1'b1};
        ridx = {1'b0, r_pos, 1'b0} + (CW+1)'(2);
        par  = AW'((r_pos - AW'(1)) >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovld  <= n_ovld;
        end
        r_in   <= n_in;
        r_scan <= n_scan;
        r_wr   <= n_wr;
        r_pos  <= n_pos;
        r_cur  <= n_cur;
        r_lft  <= n_lft;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out       = r_out;

    always_comb begin
        logic [AW-1:0] best;
        logic          go;
        logic [CW-1:0] lastc;
        n_state = r_state;
        n_in = r_in; n_cnt = r_cnt; n_scan = r_scan; n_wr = r_wr;
        n_pos = r_pos; n_cur = r_cur; n_lft = r_lft;
        n_res = r_res; n_out = r_out; n_ovld = r_ovld;
        we = 1'b0; addr = r_pos; wdata = r_cur;
        best = r_pos; go = 1'b0;
        lastc = r_cnt - CW'(1);
        if (r_ovld && i_out_ready) begin
            n_ovld = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_in  = i_in;
                    n_res = '0;
                    n_res.status = ST_OK;
                    case (i_in.mode)
                        MODE_INSERT: begin
                            if (r_cnt >= CW'(DEPTH)) begin
                                n_res.status = ST_FULL;
                                n_state = S_HEAD_RD;
                            end else begin
                                n_cur = '{i_in.entry_key, i_in.entry_id, i_in.entry_time};
                                n_pos = AW'(r_cnt);
                                n_cnt = r_cnt + CW'(1);
                                n_state = S_UP_RD;
                            end
                        end
                        MODE_POP: begin
                            if (r_cnt == '0) begin
                                n_res.status = ST_EMPTY;
                                n_state = S_HEAD_RD;
                            end else begin
                                n_state = S_POP_RD;
                            end
                        end
                        MODE_ERASE: begin
                            n_scan = '0; n_wr = '0;
                            n_state = S_ER_RD;
                        end
                        default: n_state = S_HEAD_RD;
                    endcase
                end
            end
            // pop: read root, then last entry
            S_POP_RD: begin
                addr = '0;
                n_state = S_POP_WT;
            end
            S_POP_WT: begin
                addr = AW'(lastc);
                n_res.removed_valid = 1'b1;
                n_res.removed_key  = rdata.key;
                n_res.removed_id   = rdata.id;
                n_res.removed_time = rdata.tstamp;
                n_cnt = lastc;
                n_pos = '0;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                // rdata is last entry on first pass; later r_cur already set
                if (r_pos == '0 && r_res.removed_valid && r_cnt == CW'(0)) begin
                    n_state = S_HEAD_RD;
                end else begin
                    if (r_pos == '0) n_cur = rdata;
                    addr = AW'(lidx);
                    n_state = S_DN_RL;
                end
            end
            S_DN_RL: begin
                n_lft = rdata;
                addr = AW'(ridx);
                n_state = S_DN_RR;
            end
            S_DN_RR: begin
                // hold the right child on the read port for the compare
                addr = AW'(ridx);
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (lidx < {1'b0, r_cnt} && r_lft.key < r_cur.key) begin
                    best = AW'(lidx); go = 1'b1;
                end
                if (ridx < {1'b0, r_cnt} &&
                    rdata.key < (go ? r_lft.key : r_cur.key)) begin
                    best = AW'(ridx); go = 1'b1;
                end
                we = 1'b1;
                addr = r_pos;
                if (go) begin
                    wdata = (best == AW'(lidx)) ? r_lft : rdata;
                    n_pos = best;
                    n_state = S_DN_RD;
                end else begin
                    wdata = r_cur;
                    n_state = S_HEAD_RD;
                end
            end
            // sift-up with a hole at r_pos holding r_cur
            S_UP_RD: begin
                if (r_pos == '0) begin
                    we = 1'b1; addr = '0; wdata = r_cur;
                    n_state = (r_in.mode == MODE_ERASE) ? S_ER_RD : S_HEAD_RD;
                end else begin
                    addr = par;
                    n_state = S_UP_WT;
                end
            end
            S_UP_WT: begin
                addr = par;
                n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                we = 1'b1; addr = r_pos;
                if (rdata.key > r_cur.key) begin
                    wdata = rdata;
                    n_pos = par;
                    n_state = S_UP_RD;
                end else begin
                    wdata = r_cur;
                    n_state = (r_in.mode == MODE_ERASE) ? S_ER_RD : S_HEAD_RD;
                end
            end
            // erase: compact survivors, sift each up in array order
            S_ER_RD: begin
                if (r_scan >= r_cnt) begin
                    n_cnt = r_wr;
                    n_state = S_HEAD_RD;
                end else begin
                    addr = AW'(r_scan);
                    n_state = S_ER_WT;
                end
            end
            S_ER_WT: begin
                addr = AW'(r_scan);
                n_state = S_ER_CHK;
            end
            S_ER_CHK: begin
                n_scan = r_scan + CW'(1);
                if (rdata.id == r_in.entry_id) begin
                    n_state = S_ER_RD;
                end else begin
                    n_cur = rdata;
                    n_pos = AW'(r_wr);
                    n_wr = r_wr + CW'(1);
                    n_state = S_UP_RD;
                end
            end
            S_HEAD_RD: begin
                addr = '0;
                n_state = S_HEAD_WT;
            end
            S_HEAD_WT: begin
                addr = '0;
                n_state = S_OUT;
            end
            // wait here while the previous result is still unclaimed
            S_OUT: begin
                addr = '0;
                if (!r_ovld || i_out_ready) begin
                    n_out = r_res;
                    n_out.entry_count = r_cnt;
                    n_out.head_valid  = (r_cnt != '0);
                    if (r_cnt != '0) begin
                        n_out.head_key  = rdata.key;
                        n_out.head_id   = rdata.id;
                        n_out.head_time = rdata.tstamp;
                    end
                    n_ovld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire
